// ===== hdl/msalu_pkg.sv =====
// ----------------------------------------------------------------------------
// msalu_pkg
// item types, operation codes and flag positions shared by the operand alu
// ----------------------------------------------------------------------------
package msalu_pkg;

  // operation kinds
  typedef enum logic [3:0] {
    KIND_AND = 4'd0,
    KIND_OR  = 4'd1,
    KIND_XOR = 4'd2,
    KIND_INC = 4'd3,
    KIND_DEC = 4'd4,
    KIND_RLC = 4'd5,
    KIND_RRC = 4'd6,
    KIND_RL  = 4'd7,
    KIND_RR  = 4'd8,
    KIND_SLA = 4'd9,
    KIND_SRA = 4'd10,
    KIND_SLL = 4'd11,
    KIND_SRL = 4'd12,
    KIND_RLD = 4'd13,
    KIND_RRD = 4'd14,
    KIND_NOP = 4'd15
  } kind_e;

  // operand sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  // flag bit positions
  localparam int unsigned FLAG_S = 7;
  localparam int unsigned FLAG_Z = 6;
  localparam int unsigned FLAG_H = 4;
  localparam int unsigned FLAG_V = 2;
  localparam int unsigned FLAG_N = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  op_size;
    logic [31:0] mem_value;
    logic [31:0] reg_operand;
    logic [2:0]  inc_count;
    logic [7:0]  acc_in;
    logic [7:0]  flags_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [7:0]  acc_out;
    logic [7:0]  flags_out;
  } out_item_t;

endpackage

// ===== hdl/msalu_calc.sv =====
// ----------------------------------------------------------------------------
// msalu_calc
// combinational datapath: logic ops, inc/dec, shifts, rotates, nibble rotates
// ----------------------------------------------------------------------------
module msalu_calc (
  input  msalu_pkg::in_item_t  item_i,
  output msalu_pkg::out_item_t result_o
);

  logic [31:0] mask;
  logic [31:0] d;
  logic [31:0] s;
  logic [31:0] logic_r;
  logic [15:0] d16;
  logic [15:0] inc_r;
  logic [15:0] dec_r;
  logic [15:0] shl;
  logic [15:0] shr;
  logic [15:0] sh_r;
  logic [15:0] ins_mask;
  logic [3:0]  cnt;
  logic [4:0]  lo_sum;
  logic        is_word;
  logic        d_msb;
  logic        cin;
  logic        left;
  logic        lsb_in;
  logic        msb_in;
  logic        cout;
  logic        size_ok;
  logic        logic_s;
  logic        logic_par;
  logic [15:0] id_r;
  logic        id_msb;
  logic [7:0]  mbyte;
  logic [7:0]  nib_a;
  logic [7:0]  nib_r;
  logic [7:0]  f;
  logic [31:0] value;
  logic [7:0]  acc;

  assign is_word = (item_i.op_size == msalu_pkg::SIZE_WORD);
  assign size_ok = (item_i.op_size == msalu_pkg::SIZE_BYTE) || is_word;
  assign cin     = item_i.flags_in[msalu_pkg::FLAG_C];
  assign cnt     = (item_i.inc_count == 3'd0) ? 4'd8 : {1'b0, item_i.inc_count};

  always_comb begin
    case (item_i.op_size)
      msalu_pkg::SIZE_BYTE: mask = 32'h0000_00FF;
      msalu_pkg::SIZE_WORD: mask = 32'h0000_FFFF;
      default:              mask = 32'hFFFF_FFFF;
    endcase
  end

  assign d     = item_i.mem_value & mask;
  assign s     = item_i.reg_operand & mask;
  assign d16   = d[15:0];
  assign d_msb = is_word ? d16[15] : d16[7];

  // logic ops
  always_comb begin
    case (item_i.kind)
      msalu_pkg::KIND_AND: logic_r = d & s;
      msalu_pkg::KIND_OR:  logic_r = d | s;
      default:             logic_r = d ^ s;
    endcase
    case (item_i.op_size)
      msalu_pkg::SIZE_BYTE: logic_s = logic_r[7];
      msalu_pkg::SIZE_WORD: logic_s = logic_r[15];
      default:              logic_s = logic_r[31];
    endcase
  end
  // upper bits are masked, so the 16-bit parity covers byte size too
  assign logic_par = ~(^logic_r[15:0]);

  // increment / decrement
  assign inc_r  = (d16 + {12'b0, cnt}) & mask[15:0];
  assign dec_r  = (d16 - {12'b0, cnt}) & mask[15:0];
  assign lo_sum = {1'b0, d16[3:0]} + {1'b0, cnt};
  assign id_r   = (item_i.kind == msalu_pkg::KIND_INC) ? inc_r : dec_r;
  assign id_msb = is_word ? id_r[15] : id_r[7];

  // shifts and rotates
  always_comb begin
    left   = (item_i.kind == msalu_pkg::KIND_RLC) || (item_i.kind == msalu_pkg::KIND_RL) ||
             (item_i.kind == msalu_pkg::KIND_SLA) || (item_i.kind == msalu_pkg::KIND_SLL);
    case (item_i.kind)
      msalu_pkg::KIND_RLC: lsb_in = d_msb;
      msalu_pkg::KIND_RL:  lsb_in = cin;
      default:             lsb_in = 1'b0;
    endcase
    case (item_i.kind)
      msalu_pkg::KIND_RRC: msb_in = d16[0];
      msalu_pkg::KIND_RR:  msb_in = cin;
      msalu_pkg::KIND_SRA: msb_in = d_msb;
      default:             msb_in = 1'b0;
    endcase
    ins_mask = is_word ? {msb_in, 15'b0} : {8'b0, msb_in, 7'b0};
    shl      = {d16[14:0], lsb_in} & mask[15:0];
    shr      = {1'b0, d16[15:1]} | ins_mask;
    sh_r     = left ? shl : shr;
    cout     = left ? d_msb : d16[0];
  end

  // nibble rotates, always on a byte
  assign mbyte = item_i.mem_value[7:0];
  always_comb begin
    if (item_i.kind == msalu_pkg::KIND_RLD) begin
      nib_a = {item_i.acc_in[7:4], mbyte[7:4]};
      nib_r = {mbyte[3:0], item_i.acc_in[3:0]};
    end else begin
      nib_a = {item_i.acc_in[7:4], mbyte[3:0]};
      nib_r = {item_i.acc_in[3:0], mbyte[7:4]};
    end
  end

  // result selection; anything unsupported passes the operands through
  always_comb begin
    value = item_i.mem_value;
    acc   = item_i.acc_in;
    f     = item_i.flags_in;
    if ((item_i.kind == msalu_pkg::KIND_AND || item_i.kind == msalu_pkg::KIND_OR ||
         item_i.kind == msalu_pkg::KIND_XOR) && item_i.op_size <= msalu_pkg::SIZE_LONG) begin
      value = logic_r;
      f[msalu_pkg::FLAG_Z] = (logic_r == 32'd0);
      f[msalu_pkg::FLAG_S] = logic_s;
      if (item_i.op_size != msalu_pkg::SIZE_LONG) begin
        f[msalu_pkg::FLAG_V] = logic_par;
      end
      f[msalu_pkg::FLAG_H] = (item_i.kind == msalu_pkg::KIND_AND);
      f[msalu_pkg::FLAG_N] = 1'b0;
      f[msalu_pkg::FLAG_C] = 1'b0;
    end else if ((item_i.kind == msalu_pkg::KIND_INC || item_i.kind == msalu_pkg::KIND_DEC) &&
                 size_ok) begin
      value = {16'b0, id_r};
      f[msalu_pkg::FLAG_Z] = (id_r == 16'd0);
      f[msalu_pkg::FLAG_S] = id_msb;
      if (item_i.kind == msalu_pkg::KIND_INC) begin
        f[msalu_pkg::FLAG_H] = (lo_sum > 5'd15);
        f[msalu_pkg::FLAG_V] = !d_msb && id_msb;
        f[msalu_pkg::FLAG_N] = 1'b0;
      end else begin
        f[msalu_pkg::FLAG_H] = (d16[3:0] < cnt);
        f[msalu_pkg::FLAG_V] = d_msb && !id_msb;
        f[msalu_pkg::FLAG_N] = 1'b1;
      end
    end else if (item_i.kind >= msalu_pkg::KIND_RLC && item_i.kind <= msalu_pkg::KIND_SRL &&
                 size_ok) begin
      value = {16'b0, sh_r};
      f[msalu_pkg::FLAG_C] = cout;
      f[msalu_pkg::FLAG_S] = is_word ? sh_r[15] : sh_r[7];
      f[msalu_pkg::FLAG_Z] = (sh_r == 16'd0);
      f[msalu_pkg::FLAG_V] = ~(^sh_r);
      // rl and rr keep h and n
      if (item_i.kind != msalu_pkg::KIND_RL && item_i.kind != msalu_pkg::KIND_RR) begin
        f[msalu_pkg::FLAG_H] = 1'b0;
        f[msalu_pkg::FLAG_N] = 1'b0;
      end
    end else if (item_i.kind == msalu_pkg::KIND_RLD || item_i.kind == msalu_pkg::KIND_RRD) begin
      value = {24'b0, nib_r};
      acc   = nib_a;
      f[msalu_pkg::FLAG_S] = nib_a[7];
      f[msalu_pkg::FLAG_Z] = (nib_a == 8'd0);
      f[msalu_pkg::FLAG_V] = ~(^nib_a);
      f[msalu_pkg::FLAG_H] = 1'b0;
      f[msalu_pkg::FLAG_N] = 1'b0;
    end
  end

  assign result_o.value_out = value;
  assign result_o.acc_out   = acc;
  assign result_o.flags_out = f;

endmodule

// ===== hdl/mem_operand_logic_shift_alu.sv =====
// ----------------------------------------------------------------------------
// mem_operand_logic_shift_alu
// operand alu for logic, inc/dec, shift/rotate and nibble rotate instructions
// ----------------------------------------------------------------------------
// Each item carries one instruction's operands (kind, size, memory value,
// register operand, inc/dec count, accumulator and flags) and yields one
// result item with the value to write back, the new accumulator and the new
// flags. The block is a two-register pipeline: an input register feeds the
// combinational datapath, whose answer lands in a result register. A new
// item is taken every cycle unless in_stall_o is high; an accepted item
// moves from the input register into the result register, where it is
// shown on out_item_o. Throughput is set by the single datapath pass
// between the two registers. Both stages hold their item while the next
// stage is stalled, so no item is lost; in_stall_o rises only when both
// registers are full and the output is stalled. Unsupported kinds or sizes
// return the memory value, accumulator and flags unchanged.
// ----------------------------------------------------------------------------
module mem_operand_logic_shift_alu (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  msalu_pkg::in_item_t  in_item_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output msalu_pkg::out_item_t out_item_o
);

  // input register
  logic                 in_valid_q;
  msalu_pkg::in_item_t  in_item_q;
  // result register
  logic                 out_valid_q;
  msalu_pkg::out_item_t out_item_q;
  msalu_pkg::out_item_t out_item_d;

  logic s1_ready;
  logic s2_ready;

  // a stage can load when it is empty or its item leaves this cycle
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !in_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (s2_ready && in_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

  // single pass through the datapath
  msalu_calc u_calc (
    .item_i   (in_item_q),
    .result_o (out_item_d)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hdl/msalu_checker.sv =====
// ----------------------------------------------------------------------------
// msalu_checker
// port-level checks on the operand alu, bound to the top level
// ----------------------------------------------------------------------------
module msalu_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_i,
  input msalu_pkg::in_item_t  in_item_i,
  input logic                 out_valid_i,
  input logic                 out_stall_i,
  input msalu_pkg::out_item_t out_item_i
);

  // a stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // a stalled result does not change
  a_out_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_item_i))
    else $error("result item changed while stalled");

  // with an empty result register the input side never stalls
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> !in_stall_i)
    else $error("input stalled with empty result register");

  // an item that meets a free result stage shows up at the output,
  // with the untouched flag bits carried through
  a_latency_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_i) ##1 (!out_valid_i || !out_stall_i) |=>
      out_valid_i &&
      (out_item_i.flags_out[5] == $past(in_item_i.flags_in[5], 2)) &&
      (out_item_i.flags_out[3] == $past(in_item_i.flags_in[3], 2)))
    else $error("result item missing or flag pass-through bits wrong");

endmodule

bind mem_operand_logic_shift_alu msalu_checker u_msalu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);
